@@ rtl/tlw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlw_pkg
// Shared widths, constants and the entry record of the two-level timer wheel.
// ----------------------------------------------------------------------------
package tlw_pkg;

  localparam int POOL_ENTRIES = 16;
  localparam int IDX_W        = 4;   // pool entry index
  localparam int CNT_W        = 5;   // scan counter, holds POOL_ENTRIES itself
  localparam int SLOT_W       = 4;   // 16 fine slots, 16 coarse slots
  localparam int DUR_W        = 16;
  localparam int ID_W         = 3;

  localparam int FINE_SLOTS   = 16;
  localparam int COARSE_SLOTS = 16;
  localparam int TICK_MS      = 10;

  // command and result codes
  localparam logic CMD_ARM      = 1'b0;
  localparam logic CMD_TICK     = 1'b1;
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_DROPPED = 1'b1;

  // ms to ticks: x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [DUR_W-1:0] TICK_RECIP = 16'd52429;
  localparam int               RECIP_SHIFT = 19;
  localparam int               PROD_W      = 2 * DUR_W;
  localparam int               TICKS_W     = PROD_W - RECIP_SHIFT;

  // one full turn of the fine wheel in ms (16 slots of 10 ms)
  localparam logic [DUR_W-1:0] TURN_MS = DUR_W'(FINE_SLOTS * TICK_MS);

  typedef struct packed {
    logic              level;     // 1: coarse wheel
    logic [SLOT_W-1:0] slot;
    logic [DUR_W-1:0]  duration;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage
`default_nettype wire

@@ rtl/two_level_timer_wheel.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_timer_wheel
// Hierarchical timing wheel over a 16-entry pool held in one memory.
// ----------------------------------------------------------------------------
// Command channel: a word (cmd, timer_id, duration_ms) is taken at a clock
// edge with start high and busy low. cmd 0 arms a timer, cmd 1 is one tick.
// Result channel: strobe marks one word on kind, expired_id and last for a
// single cycle; the receiver cannot stall it, so every word must be taken.
// An arm first finds the lowest free entry and forms the tick count, then
// writes the entry. A pool-full arm yields one word with kind 1 and last 1,
// on the port in the same cycle in which busy falls.
// A tick sweeps the entry memory one address per cycle (16 reads) through a
// three-stage read, scale and write-back pipeline, then drains it. Cascade
// and expiry are decided in the same pass. Expiry words come out in
// ascending entry order; each is held one stage so that the final one can
// carry last, which leaves the tail word on the port in the cycle in which
// busy falls.
// Reset clears all entry valid flags and both cursors; memory contents are
// never cleared and are read only behind a valid flag.
// ----------------------------------------------------------------------------
module two_level_timer_wheel
  import tlw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd,
  input  wire logic [ID_W-1:0]   timer_id,
  input  wire logic [DUR_W-1:0]  duration_ms,
  output logic                   strobe,
  output logic                   kind,
  output logic [ID_W-1:0]        expired_id,
  output logic                   last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ARM  = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;

  logic [1:0] state, state_next;

  logic [POOL_ENTRIES-1:0] entry_valid;
  logic [SLOT_W-1:0]       fine_cursor;
  logic [SLOT_W-1:0]       coarse_cursor;

  // entry memory
  entry_t             mem [POOL_ENTRIES];
  entry_t             rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  // arm registers
  logic [IDX_W-1:0]   arm_idx;
  logic               arm_free;
  logic [ID_W-1:0]    arm_id;
  logic [DUR_W-1:0]   arm_dur;
  logic [PROD_W-1:0]  arm_prod;

  // tick sweep
  logic [CNT_W-1:0]   iss_cnt;
  logic               issue;
  logic               s1_vld;
  logic [IDX_W-1:0]   s1_idx;
  logic               s2_vld;
  logic [IDX_W-1:0]   s2_idx;
  logic               s2_live;
  entry_t             s2_ent;
  logic [PROD_W-1:0]  s2_prod;
  logic               scan_done;

  logic               pend_vld;
  logic [ID_W-1:0]    pend_id;

  // combinational helpers
  logic [IDX_W-1:0]   free_idx;
  logic               free_any;
  logic [TICKS_W-1:0] arm_ticks;
  logic [TICKS_W-1:0] s2_ticks;
  logic               s2_cascade;
  entry_t             s2_new;
  logic               s2_expire;
  logic               accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // lowest free entry
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  assign arm_ticks = arm_prod[PROD_W-1:RECIP_SHIFT];
  assign s2_ticks  = s2_prod[PROD_W-1:RECIP_SHIFT];

  assign issue     = (iss_cnt[CNT_W-1] == 1'b0);
  assign rd_addr   = iss_cnt[IDX_W-1:0];
  assign scan_done = !issue && !s1_vld && !s2_vld;

  // cascade then expiry for the entry in the last stage
  always_comb begin
    s2_cascade = s2_live && s2_ent.level && (s2_ent.slot == coarse_cursor) &&
                 (fine_cursor == '0);
    s2_new     = s2_ent;
    if (s2_cascade) begin
      s2_new.level    = 1'b0;
      s2_new.slot     = s2_ticks[SLOT_W-1:0];
      s2_new.duration = s2_ent.duration -
                        DUR_W'({{(DUR_W-TICKS_W+SLOT_W){1'b0}},
                                s2_ticks[TICKS_W-1:SLOT_W]} * TURN_MS);
    end
    s2_expire = s2_vld && s2_live && !s2_new.level && (s2_new.slot == fine_cursor);
  end

  // memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = arm_idx;
    wr_data = '0;
    wr_data.id       = arm_id;
    wr_data.duration = arm_dur;
    if (arm_ticks[TICKS_W-1:SLOT_W] != '0) begin
      wr_data.level = 1'b1;
      wr_data.slot  = coarse_cursor + arm_ticks[2*SLOT_W-1:SLOT_W];
    end else begin
      wr_data.level = 1'b0;
      wr_data.slot  = fine_cursor + arm_ticks[SLOT_W-1:0];
    end
    unique case (state)
      ST_ARM: begin
        wr_en = arm_free;
      end
      ST_TICK: begin
        wr_en   = s2_vld && s2_cascade && !s2_expire;
        wr_addr = s2_idx;
        wr_data = s2_new;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd == CMD_ARM) ? ST_ARM : ST_TICK;
        end
      end
      ST_ARM: begin
        state_next = ST_IDLE;
      end
      ST_TICK: begin
        if (scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      arm_idx  <= free_idx;
      arm_free <= free_any;
      arm_id   <= timer_id;
      arm_dur  <= duration_ms;
      arm_prod <= duration_ms * TICK_RECIP;
    end
    s1_idx  <= rd_addr;
    s2_idx  <= s1_idx;
    s2_ent  <= rd_data;
    s2_live <= entry_valid[s1_idx];
    s2_prod <= rd_data.duration * TICK_RECIP;
    if (s2_expire) begin
      pend_id <= s2_new.id;
    end
  end

  // control and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_valid   <= '0;
      fine_cursor   <= '0;
      coarse_cursor <= '0;
      iss_cnt       <= '0;
      s1_vld        <= 1'b0;
      s2_vld        <= 1'b0;
      pend_vld      <= 1'b0;
      strobe        <= 1'b0;
      kind          <= KIND_EXPIRED;
      expired_id    <= '0;
      last          <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      s1_vld <= (state == ST_TICK) && issue;
      s2_vld <= s1_vld;
      if (accept) begin
        iss_cnt <= '0;
      end else if ((state == ST_TICK) && issue) begin
        iss_cnt <= iss_cnt + 1'b1;
      end
      if (state == ST_ARM) begin
        if (arm_free) begin
          entry_valid[arm_idx] <= 1'b1;
        end else begin
          strobe     <= 1'b1;
          kind       <= KIND_DROPPED;
          expired_id <= arm_id;
          last       <= 1'b1;
        end
      end
      if ((state == ST_TICK) && s2_expire) begin
        entry_valid[s2_idx] <= 1'b0;
        pend_vld            <= 1'b1;
        // hand out the word held back, now known not to be the final one
        if (pend_vld) begin
          strobe     <= 1'b1;
          kind       <= KIND_EXPIRED;
          expired_id <= pend_id;
          last       <= 1'b0;
        end
      end
      if ((state == ST_TICK) && scan_done) begin
        fine_cursor <= fine_cursor + 1'b1;
        if (fine_cursor == '0) begin
          coarse_cursor <= coarse_cursor + 1'b1;
        end
        pend_vld <= 1'b0;
        if (pend_vld) begin
          strobe     <= 1'b1;
          kind       <= KIND_EXPIRED;
          expired_id <= pend_id;
          last       <= 1'b1;
        end
      end
    end
  end

  // checks
  a_wr_in_work: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_ARM || state == ST_TICK))
    else $error("entry memory written outside arm or tick");

  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == KIND_DROPPED) |-> last)
    else $error("dropped arm word not marked last");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    iss_cnt <= CNT_W'(POOL_ENTRIES))
    else $error("sweep counter beyond pool");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_cursor_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK && scan_done) |=>
      fine_cursor == SLOT_W'($past(fine_cursor) + 1'b1))
    else $error("fine cursor did not advance at end of tick");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two-level timer wheel testbench
// Arms timers and issues ticks through the command channel. A scoreboard
// keeps its own copy of the entry pool and both wheel cursors, predicts the
// expiry and drop words of every accepted command, and checks each strobed
// result word against the oldest prediction.
// ----------------------------------------------------------------------------
import tlw_pkg::*;

typedef struct packed {
  logic            kind;
  logic [ID_W-1:0] id;
  logic            last;
} wheel_word_t;

class wheel_scoreboard;
  bit                 valid [POOL_ENTRIES];
  bit                 level [POOL_ENTRIES];
  int unsigned        slot  [POOL_ENTRIES];
  int unsigned        dur   [POOL_ENTRIES];
  logic [ID_W-1:0]    tid   [POOL_ENTRIES];
  int unsigned        fine_pos;
  int unsigned        coarse_pos;
  wheel_word_t        due_words [$];
  int                 arms, drops, ticks, expiries, cascades, checked, mismatches;

  function new();
    foreach (valid[i]) valid[i] = 1'b0;
    fine_pos   = 0;
    coarse_pos = 0;
  endfunction

  // predict the words caused by one accepted command
  function void take_command(logic c, logic [ID_W-1:0] id, logic [DUR_W-1:0] d);
    int unsigned t;
    int          hit [$];
    wheel_word_t w;
    bit          placed;
    if (c == CMD_ARM) begin
      arms++;
      t = d / TICK_MS;
      placed = 1'b0;
      for (int i = 0; i < POOL_ENTRIES && !placed; i++) begin
        if (!valid[i]) begin
          placed   = 1'b1;
          valid[i] = 1'b1;
          dur[i]   = d;
          tid[i]   = id;
          if (t >= FINE_SLOTS) begin
            level[i] = 1'b1;
            slot[i]  = (coarse_pos + t / FINE_SLOTS) % COARSE_SLOTS;
          end else begin
            level[i] = 1'b0;
            slot[i]  = (fine_pos + t) % FINE_SLOTS;
          end
        end
      end
      if (!placed) begin
        drops++;
        w.kind = KIND_DROPPED;
        w.id   = id;
        w.last = 1'b1;
        due_words.push_back(w);
      end
    end else begin
      ticks++;
      if (fine_pos == 0) begin
        // pull the current coarse slot down into the fine wheel
        for (int i = 0; i < POOL_ENTRIES; i++) begin
          if (valid[i] && level[i] && slot[i] == coarse_pos) begin
            level[i] = 1'b0;
            slot[i]  = (dur[i] / TICK_MS) % FINE_SLOTS;
            dur[i]   = dur[i] % (FINE_SLOTS * TICK_MS);
            cascades++;
          end
        end
        coarse_pos = (coarse_pos + 1) % COARSE_SLOTS;
      end
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        if (valid[i] && !level[i] && slot[i] == fine_pos) begin
          valid[i] = 1'b0;
          hit.push_back(i);
        end
      end
      foreach (hit[k]) begin
        w.kind = KIND_EXPIRED;
        w.id   = tid[hit[k]];
        w.last = (k == hit.size() - 1);
        due_words.push_back(w);
      end
      expiries += hit.size();
      fine_pos = (fine_pos + 1) % FINE_SLOTS;
    end
  endfunction

  function void flag(string what, wheel_word_t want, wheel_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected kind=%0d id=%0d last=%0d, got kind=%0d id=%0d last=%0d",
               $time, what, want.kind, want.id, want.last, got.kind, got.id, got.last);
  endfunction

  function void compare_word(logic k, logic [ID_W-1:0] id, logic l);
    wheel_word_t got, want;
    got.kind = k;
    got.id   = id;
    got.last = l;
    checked++;
    if (due_words.size() == 0) begin
      want = '0;
      flag("result word with none pending", want, got);
    end else begin
      want = due_words.pop_front();
      if (got.kind !== want.kind || got.id !== want.id || got.last !== want.last)
        flag("result word mismatch", want, got);
    end
  endfunction
endclass

module testbench;

  localparam int LIMIT        = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 180;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              cmd;
  logic [ID_W-1:0]   timer_id;
  logic [DUR_W-1:0]  duration_ms;
  logic              strobe;
  logic              kind;
  logic [ID_W-1:0]   expired_id;
  logic              last;

  wheel_scoreboard   sb;
  int                cycles = 0;
  bit                steady;

  two_level_timer_wheel uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .timer_id    (timer_id),
    .duration_ms (duration_ms),
    .strobe      (strobe),
    .kind        (kind),
    .expired_id  (expired_id),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // both channels are sampled at the edge, before any new drive lands
  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.take_command(cmd, timer_id, duration_ms);
    if (!rst && strobe)
      sb.compare_word(kind, expired_id, last);
  end

  // hold the word until it is taken
  task automatic issue(input logic c, input logic [ID_W-1:0] id,
                       input logic [DUR_W-1:0] d);
    cmd         <= c;
    timer_id    <= id;
    duration_ms <= d;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // mostly fine-wheel and near coarse delays so that cascades come round
  function automatic logic [DUR_W-1:0] arm_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 47) return DUR_W'($urandom_range(0, FINE_SLOTS * TICK_MS - 1));
    if (r < 92) return DUR_W'($urandom_range(FINE_SLOTS * TICK_MS, 1279));
    return DUR_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    sb = new();
    steady      = 1'b0;
    rst         <= 1'b1;
    start       <= 1'b0;
    cmd         <= CMD_ARM;
    timer_id    <= '0;
    duration_ms <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill the pool into one fine slot, overflow it, then expire all sixteen
    for (int k = 0; k < POOL_ENTRIES; k++) begin
      issue(CMD_ARM, k[ID_W-1:0], (k == 0) ? 16'd0 : 16'($urandom_range(0, TICK_MS - 1)));
      pause(pick_gap());
    end
    issue(CMD_ARM, 3'd5, 16'd4);
    pause(pick_gap());
    issue(CMD_TICK, 3'd0, 16'd0);
    pause(pick_gap());
    issue(CMD_ARM, 3'd7, 16'hffff);
    issue(CMD_ARM, 3'd3, 16'(FINE_SLOTS * TICK_MS - 1));
    issue(CMD_ARM, 3'd6, 16'(FINE_SLOTS * TICK_MS));
    // empty slot: no word
    issue(CMD_TICK, 3'd7, 16'hffff);
    pause(pick_gap());

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 30 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) begin
        // drain everything before going on
        start <= 1'b0;
        @(posedge clk);
        while (sb.due_words.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 55)
        issue(CMD_TICK, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
      else
        issue(CMD_ARM, 3'($urandom_range(0, 7)), arm_delay());
      pause(pick_gap());
    end
    start <= 1'b0;

    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d arms (%0d dropped on a full pool), %0d ticks, %0d cascaded entries",
             sb.arms, sb.drops, sb.ticks, sb.cascades);
    $display("%0d expiries predicted, %0d result words checked, %0d mismatches",
             sb.expiries, sb.checked, sb.mismatches);
    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tlw_pkg.sv
rtl/two_level_timer_wheel.sv
test/testbench.sv
